// ----- design/lfps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lfps_pkg;

    localparam int SENSORS    = 8;
    localparam int GAIN_W     = 8;
    localparam int SPEED_W    = 10;
    localparam int STEER_W    = 11;
    localparam int OQ_W       = STEER_W + 1;
    localparam int RAW_W      = 7;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int UPC_W      = 4;
    localparam int SUM_W      = 9;
    localparam int CNT_W      = 4;
    localparam int QUO_W      = 6;
    localparam int DVS_W      = 9;

    localparam logic [GAIN_W-1:0] ALPHA_NUM   = 8'd179;
    localparam logic [GAIN_W-1:0] ALPHA_REST  = 8'd77;
    localparam int                ALPHA_SHIFT = 8;
    localparam int                ALPHA_ROUND = (1 << ALPHA_SHIFT) - 1;
    localparam int                LOST_MAG    = 40;

    localparam logic signed [RAW_W-1:0]   LOST_ERROR = 7'sd40;
    localparam logic [SENSORS-1:0]        EDGE_MASK  = 8'h81;
    localparam logic signed [STEER_W-1:0] STEER_MAX  = 11'sd1023;
    localparam logic signed [STEER_W-1:0] STEER_MIN  = -11'sd1024;
    localparam logic [UPC_W-1:0]          UPC_LAST   = 4'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_STRAIGHT    = 3'd0,
        REG_KD_STRAIGHT    = 3'd1,
        REG_KP_TURN        = 3'd2,
        REG_KD_TURN        = 3'd3,
        REG_KI_GAIN        = 3'd4,
        REG_BIAS_OFFSET    = 3'd5,
        REG_SPEED_STRAIGHT = 3'd6,
        REG_SPEED_TURN     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_straight;
        logic [GAIN_W-1:0]  kd_straight;
        logic [GAIN_W-1:0]  kp_turn;
        logic [GAIN_W-1:0]  kd_turn;
        logic [GAIN_W-1:0]  ki_gain;
        logic [GAIN_W-1:0]  bias_offset;
        logic [SPEED_W-1:0] speed_straight;
        logic [SPEED_W-1:0] speed_turn;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        kp_straight:    8'd40,
        kd_straight:    8'd0,
        kp_turn:        8'd80,
        kd_turn:        8'd40,
        ki_gain:        8'd0,
        bias_offset:    8'd25,
        speed_straight: 10'd400,
        speed_turn:     10'd250
    };

    typedef enum logic [2:0] {
        DP_NOP,
        DP_DIV,
        DP_RAW,
        DP_FILT,
        DP_INTEG,
        DP_CLAMP,
        DP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        A_ALPHA_NUM,
        A_ALPHA_REST,
        A_KP,
        A_KI,
        A_KD
    } a_sel_t;

    typedef enum logic [1:0] {
        B_RAW,
        B_FE,
        B_INTEG,
        B_DERIV
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_DIV_LOOP,
        JMP_END
    } jmp_t;

    typedef struct packed {
        dp_op_t  dp_op;
        logic    mul_en;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
    } uop_t;

    typedef struct packed {
        uop_t uop;
        jmp_t jmp;
    } uword_t;

    typedef struct packed {
        logic start;
        uop_t uop;
    } ctrl_t;

    typedef struct packed {
        logic div_last;
        logic out_block;
    } stat_t;

    localparam uop_t UOP_NOP = '{
        dp_op:  DP_NOP,
        mul_en: 1'b0,
        a_sel:  A_KP,
        b_sel:  B_FE,
        acc_op: ACC_HOLD
    };

    // sensor index counted from the left edge
    function automatic logic signed [RAW_W-1:0] pos_weight(input logic [2:0] idx);
        logic signed [RAW_W-1:0] w;
        case (idx)
            3'd0:    w = -7'sd35;
            3'd1:    w = -7'sd25;
            3'd2:    w = -7'sd15;
            3'd3:    w = -7'sd5;
            3'd4:    w = 7'sd5;
            3'd5:    w = 7'sd15;
            3'd6:    w = 7'sd25;
            default: w = 7'sd35;
        endcase
        return w;
    endfunction

    // control store
    function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
        uword_t w;
        w.uop = UOP_NOP;
        w.jmp = JMP_NEXT;
        unique case (upc)
            4'd0: begin
                w.uop.dp_op = DP_DIV;
                w.jmp       = JMP_DIV_LOOP;
            end
            4'd1: w.uop.dp_op = DP_RAW;
            4'd2: begin
                w.uop.mul_en = 1'b1;
                w.uop.a_sel  = A_ALPHA_NUM;
                w.uop.b_sel  = B_RAW;
            end
            4'd3: begin
                w.uop.mul_en = 1'b1;
                w.uop.a_sel  = A_ALPHA_REST;
                w.uop.b_sel  = B_FE;
                w.uop.acc_op = ACC_LOAD;
            end
            4'd4: w.uop.acc_op = ACC_ADD;
            4'd5: w.uop.dp_op = DP_FILT;
            4'd6: begin
                w.uop.dp_op  = DP_INTEG;
                w.uop.mul_en = 1'b1;
                w.uop.a_sel  = A_KP;
                w.uop.b_sel  = B_FE;
            end
            4'd7: begin
                w.uop.mul_en = 1'b1;
                w.uop.a_sel  = A_KI;
                w.uop.b_sel  = B_INTEG;
                w.uop.acc_op = ACC_LOAD;
            end
            4'd8: begin
                w.uop.mul_en = 1'b1;
                w.uop.a_sel  = A_KD;
                w.uop.b_sel  = B_DERIV;
                w.uop.acc_op = ACC_ADD;
            end
            4'd9:  w.uop.acc_op = ACC_ADD;
            4'd10: w.uop.dp_op = DP_CLAMP;
            4'd11: begin
                w.uop.dp_op = DP_OUT;
                w.jmp       = JMP_END;
            end
            default: w.jmp = JMP_END;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/lfps_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfps_cfg_regs
    import lfps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_KP_STRAIGHT:    cfg_next.kp_straight    = cfg_data[GAIN_W-1:0];
                REG_KD_STRAIGHT:    cfg_next.kd_straight    = cfg_data[GAIN_W-1:0];
                REG_KP_TURN:        cfg_next.kp_turn        = cfg_data[GAIN_W-1:0];
                REG_KD_TURN:        cfg_next.kd_turn        = cfg_data[GAIN_W-1:0];
                REG_KI_GAIN:        cfg_next.ki_gain        = cfg_data[GAIN_W-1:0];
                REG_BIAS_OFFSET:    cfg_next.bias_offset    = cfg_data[GAIN_W-1:0];
                REG_SPEED_STRAIGHT: cfg_next.speed_straight = cfg_data[SPEED_W-1:0];
                REG_SPEED_TURN:     cfg_next.speed_turn     = cfg_data[SPEED_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/lfps_useq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfps_useq
    import lfps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    logic             busy_reg;
    logic             busy_next;
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           uword;
    logic             stall;
    logic             exec;
    logic             start;

    assign uword    = ucode(upc_reg);
    assign stall    = (uword.jmp == JMP_END) && stat.out_block;
    assign exec     = busy_reg && !stall;
    assign start    = in_valid && !busy_reg;
    assign in_ready = !busy_reg;

    always_comb
    begin
        ctrl.start = start;
        ctrl.uop   = exec ? uword.uop : UOP_NOP;
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = '0;
        end
        else if (exec)
        begin
            unique case (uword.jmp)
                JMP_NEXT:     upc_next = upc_reg + 1'b1;
                JMP_DIV_LOOP: upc_next = stat.div_last ? upc_reg + 1'b1 : upc_reg;
                JMP_END:
                begin
                    busy_next = 1'b0;
                    upc_next  = '0;
                end
                default:      upc_next = upc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> busy_reg && upc_reg == '0)
        else $error("sequencer did not start after input transfer");

    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> upc_reg <= UPC_LAST)
        else $error("step counter past end of program");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && stall |=> busy_reg && $stable(upc_reg))
        else $error("final step left while result still waiting");

endmodule

`default_nettype wire

// ----- design/lfps_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfps_dp
    import lfps_pkg::*;
#(
    parameter int FRAC_BITS      = 8,
    parameter int OUTPUT_LIMIT   = 800,
    parameter int INTEGRAL_LIMIT = 500
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctrl,
    input  wire cfg_t               cfg,
    input  wire logic [SENSORS-1:0] sensor_bits,
    input  wire logic               out_ready,
    output stat_t                   stat,
    output logic                    out_valid,
    output logic [SPEED_W-1:0]      speed_cmd,
    output logic [STEER_W-1:0]      steer_cmd,
    output logic                    turn_mode,
    output logic                    line_lost
);

    localparam int FEW = FRAC_BITS + RAW_W;
    localparam int DW  = FEW + 1;
    localparam int IW  = $clog2(INTEGRAL_LIMIT + 1) + FRAC_BITS + 1;
    localparam int SW  = ((IW > FEW) ? IW : FEW) + 1;
    localparam int BW  = (IW > DW) ? IW : DW;
    localparam int PW  = BW + GAIN_W + 1;
    localparam int AW  = PW + 2;

    localparam logic signed [SW-1:0]  ILIM      = SW'(INTEGRAL_LIMIT) <<< FRAC_BITS;
    localparam logic signed [SW-1:0]  ILIM_N    = -ILIM;
    localparam logic signed [AW-1:0]  OUT_LIM   = AW'(OUTPUT_LIMIT) <<< FRAC_BITS;
    localparam logic signed [AW-1:0]  OUT_LIM_N = -OUT_LIM;
    localparam logic signed [AW-1:0]  FRAC_RND  = AW'((1 << FRAC_BITS) - 1);
    localparam logic signed [AW-1:0]  FILT_RND  = AW'(ALPHA_ROUND);
    localparam logic signed [FEW-1:0] FE_LIM    = FEW'(LOST_MAG) <<< FRAC_BITS;

    // sample intake
    logic signed [SUM_W-1:0] in_sum;
    logic [CNT_W-1:0]        in_cnt;
    logic [SUM_W-1:0]        in_thr;
    logic                    in_lost;
    logic                    in_turn;

    always_comb
    begin
        in_sum = '0;
        in_cnt = '0;
        for (int i = 0; i < SENSORS; i++)
        begin
            if (!sensor_bits[SENSORS-1-i])
            begin
                in_sum = in_sum + SUM_W'(pos_weight(3'(i)));
                in_cnt = in_cnt + 1'b1;
            end
        end
        in_thr  = SUM_W'({in_cnt, 2'b00}) + SUM_W'(in_cnt);
        in_lost = (in_cnt == '0);
        in_turn = in_lost || (in_sum > $signed(in_thr)) || (in_sum < -$signed(in_thr))
                  || ((sensor_bits & EDGE_MASK) != EDGE_MASK);
    end

    // divider and error state
    logic                    sum_neg_reg, sum_neg_next;
    logic [SUM_W-2:0]        rem_reg, rem_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [2:0]              div_cnt_reg, div_cnt_next;
    logic                    lost_reg, lost_next;
    logic                    turn_reg, turn_next;
    logic signed [RAW_W-1:0] raw_reg, raw_next;
    logic signed [RAW_W-1:0] lve_reg, lve_next;
    logic                    div_ge;

    // arithmetic state
    logic signed [FEW-1:0] fe_reg, fe_next;
    logic signed [FEW-1:0] pfe_reg, pfe_next;
    logic signed [IW-1:0]  integ_reg, integ_next;
    logic signed [DW-1:0]  deriv_reg, deriv_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [AW-1:0]  acc_reg, acc_next;

    logic [GAIN_W-1:0]      a_gain;
    logic signed [GAIN_W:0] a_op;
    logic signed [BW-1:0]   b_op;
    logic signed [AW-1:0]   filt_round;
    logic signed [AW-1:0]   filt_q;
    logic signed [SW-1:0]   isum;
    logic signed [AW-1:0]   oq_round;
    logic signed [AW-1:0]   oq_full;
    logic signed [OQ_W-1:0] steer_sum;

    // result register
    logic                      out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]        speed_reg, speed_next;
    logic signed [STEER_W-1:0] steer_reg, steer_next;
    logic                      turn_out_reg, turn_out_next;
    logic                      lost_out_reg, lost_out_next;

    assign div_ge = {1'b0, rem_reg} >= dvs_reg;

    always_comb
    begin
        case (ctrl.uop.a_sel)
            A_ALPHA_NUM:  a_gain = ALPHA_NUM;
            A_ALPHA_REST: a_gain = ALPHA_REST;
            A_KP:         a_gain = turn_reg ? cfg.kp_turn : cfg.kp_straight;
            A_KI:         a_gain = cfg.ki_gain;
            A_KD:         a_gain = turn_reg ? cfg.kd_turn : cfg.kd_straight;
            default:      a_gain = '0;
        endcase
        case (ctrl.uop.b_sel)
            B_RAW:   b_op = BW'(raw_reg) <<< FRAC_BITS;
            B_FE:    b_op = BW'(fe_reg);
            B_INTEG: b_op = BW'(integ_reg);
            B_DERIV: b_op = BW'(deriv_reg);
            default: b_op = '0;
        endcase
        a_op      = $signed({1'b0, a_gain});
        prod_next = a_op * b_op;
    end

    always_comb
    begin
        filt_round = acc_reg + (acc_reg[AW-1] ? FILT_RND : AW'(0));
        filt_q     = filt_round >>> ALPHA_SHIFT;
        isum       = SW'(integ_reg) + SW'(fe_reg);
        oq_round   = acc_reg + (acc_reg[AW-1] ? FRAC_RND : AW'(0));
        oq_full    = oq_round >>> FRAC_BITS;
        steer_sum  = $signed(oq_full[OQ_W-1:0]) + OQ_W'($signed(cfg.bias_offset));
    end

    always_comb
    begin
        sum_neg_next   = sum_neg_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        lost_next      = lost_reg;
        turn_next      = turn_reg;
        raw_next       = raw_reg;
        lve_next       = lve_reg;
        fe_next        = fe_reg;
        pfe_next       = pfe_reg;
        integ_next     = integ_reg;
        deriv_next     = deriv_reg;
        acc_next       = acc_reg;
        speed_next     = speed_reg;
        steer_next     = steer_reg;
        turn_out_next  = turn_out_reg;
        lost_out_next  = lost_out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (ctrl.start)
        begin
            sum_neg_next = in_sum[SUM_W-1];
            rem_next     = in_sum[SUM_W-1] ? (SUM_W-1)'(-in_sum) : in_sum[SUM_W-2:0];
            dvs_next     = DVS_W'(in_cnt) << (QUO_W - 1);
            quo_next     = '0;
            div_cnt_next = 3'(QUO_W - 1);
            lost_next    = in_lost;
            turn_next    = in_turn;
        end

        case (ctrl.uop.acc_op)
            ACC_LOAD: acc_next = AW'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + AW'(prod_reg);
            default:  acc_next = acc_reg;
        endcase

        unique case (ctrl.uop.dp_op)
            DP_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dvs_reg[SUM_W-2:0];
                end
                quo_next     = {quo_reg[QUO_W-2:0], div_ge};
                dvs_next     = dvs_reg >> 1;
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            DP_RAW:
            begin
                if (lost_reg)
                begin
                    if (lve_reg[RAW_W-1])
                        raw_next = -LOST_ERROR;
                    else if (lve_reg != '0)
                        raw_next = LOST_ERROR;
                    else
                        raw_next = '0;
                end
                else
                begin
                    raw_next = sum_neg_reg ? -$signed(RAW_W'(quo_reg)) : $signed(RAW_W'(quo_reg));
                    lve_next = raw_next;
                end
            end
            DP_FILT: fe_next = filt_q[FEW-1:0];
            DP_INTEG:
            begin
                if (isum > ILIM)
                    integ_next = IW'(ILIM);
                else if (isum < ILIM_N)
                    integ_next = IW'(ILIM_N);
                else
                    integ_next = IW'(isum);
                deriv_next = DW'(fe_reg) - DW'(pfe_reg);
                pfe_next   = fe_reg;
            end
            DP_CLAMP:
            begin
                if (acc_reg > OUT_LIM)
                    acc_next = OUT_LIM;
                else if (acc_reg < OUT_LIM_N)
                    acc_next = OUT_LIM_N;
            end
            DP_OUT:
            begin
                out_valid_next = 1'b1;
                speed_next     = turn_reg ? cfg.speed_turn : cfg.speed_straight;
                turn_out_next  = turn_reg;
                lost_out_next  = lost_reg;
                if (steer_sum > OQ_W'(STEER_MAX))
                    steer_next = STEER_MAX;
                else if (steer_sum < OQ_W'(STEER_MIN))
                    steer_next = STEER_MIN;
                else
                    steer_next = steer_sum[STEER_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fe_reg        <= '0;
            pfe_reg       <= '0;
            integ_reg     <= '0;
            lve_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fe_reg        <= fe_next;
            pfe_reg       <= pfe_next;
            integ_reg     <= integ_next;
            lve_reg       <= lve_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_neg_reg  <= sum_neg_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        quo_reg      <= quo_next;
        div_cnt_reg  <= div_cnt_next;
        lost_reg     <= lost_next;
        turn_reg     <= turn_next;
        raw_reg      <= raw_next;
        deriv_reg    <= deriv_next;
        acc_reg      <= acc_next;
        speed_reg    <= speed_next;
        steer_reg    <= steer_next;
        turn_out_reg <= turn_out_next;
        lost_out_reg <= lost_out_next;
        if (ctrl.uop.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        stat.div_last  = (div_cnt_reg == '0);
        stat.out_block = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign speed_cmd = speed_reg;
    assign steer_cmd = steer_reg;
    assign turn_mode = turn_out_reg;
    assign line_lost = lost_out_reg;

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.uop.dp_op == DP_OUT |=> out_valid_reg)
        else $error("result not presented after output step");

    a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(integ_reg) <= ILIM) && (SW'(integ_reg) >= ILIM_N))
        else $error("integral outside its clamp");

    a_fe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fe_reg <= FE_LIM) && (fe_reg >= -FE_LIM))
        else $error("filtered error outside its range");

endmodule

`default_nettype wire

// ----- design/line_follow_pid_steering_unit.sv -----
// Line-follower steering controller. Each transfer on the input channel carries one
// sensor byte (bit 7 leftmost, 0 = line seen); the block returns one result with the
// speed command, the steering command, the turn flag and the line-lost flag. Work is
// done by a 12-word microprogram driving one shared 9 x (FRAC_BITS+10) bit multiplier
// and accumulator: shift-subtract division for the position average, then 11 steps for
// the low-pass filter, integral, derivative and output clamp. The final step registers
// the result and frees the input, and the next sample can be taken in the cycle after;
// no new sample is taken while one is in work. A result not yet taken holds the final
// step until the output register frees. Gains, bias and speeds must be written through
// the cfg_we/cfg_index/cfg_data port only while the block is idle; it does not check this.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pid_steering_unit
    import lfps_pkg::*;
#(
    parameter int FRAC_BITS      = 8,
    parameter int OUTPUT_LIMIT   = 800,
    parameter int INTEGRAL_LIMIT = 500
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SENSORS-1:0]    sensor_bits,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [SPEED_W-1:0]         speed_cmd,
    output logic [STEER_W-1:0]         steer_cmd,
    output logic                       turn_mode,
    output logic                       line_lost
);

    cfg_t  cfg;
    ctrl_t ctrl;
    stat_t stat;

    lfps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfps_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    lfps_dp #(
        .FRAC_BITS      (FRAC_BITS),
        .OUTPUT_LIMIT   (OUTPUT_LIMIT),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cfg         (cfg),
        .sensor_bits (sensor_bits),
        .out_ready   (out_ready),
        .stat        (stat),
        .out_valid   (out_valid),
        .speed_cmd   (speed_cmd),
        .steer_cmd   (steer_cmd),
        .turn_mode   (turn_mode),
        .line_lost   (line_lost)
    );

endmodule

`default_nettype wire
